/* src/csem_pkg.sv */
package csem_pkg;

    // table geometry and field widths
    localparam int NUM_SEMS    = 16;
    localparam int QUEUE_DEPTH = 16;
    localparam int PID_BITS    = 16;
    localparam int COUNT_BITS  = 16;

    localparam int SLOT_W    = $clog2(NUM_SEMS);
    localparam int LEN_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_SEMS * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam logic [32:0]           COUNT_MAX_W = (33'd1 << COUNT_BITS) - 33'd1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;

    // command codes on the input channel
    typedef enum logic [2:0] {
        CMD_OPEN   = 3'd0,
        CMD_CLOSE  = 3'd1,
        CMD_POST   = 3'd2,
        CMD_WAIT   = 3'd3,
        CMD_REMOVE = 3'd4
    } cmd_t;

    // result status codes
    typedef enum logic [2:0] {
        STS_OK          = 3'd0,
        STS_BLOCKED     = 3'd1,
        STS_TABLE_FULL  = 3'd2,
        STS_NOT_FOUND   = 3'd3,
        STS_HAS_WAITERS = 3'd4,
        STS_QUEUE_FULL  = 3'd5,
        STS_OVERFLOW    = 3'd6
    } status_t;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_OPEN,
        OP_CLOSE,
        OP_POST,
        OP_WAIT,
        OP_REMOVE,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [31:0]           sem_id;
        logic [COUNT_BITS-1:0] init;
        logic                  init_sat;
        logic [PID_BITS-1:0]   pid;
    } job_t;

    // flat address of one queue entry
    function automatic logic [ADDR_W-1:0] qaddr(logic [SLOT_W-1:0] s, logic [LEN_W-1:0] p);
        return ADDR_W'(s) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
    endfunction

endpackage

/* src/csem_cmd_if.sv */
interface csem_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [31:0] sem_id;
    logic [15:0] init_count;
    logic [15:0] pid;

    modport source (output valid, command, sem_id, init_count, pid, input ready);
    modport sink (input valid, command, sem_id, init_count, pid, output ready);
endinterface

/* src/csem_res_if.sv */
interface csem_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        woken_valid;
    logic [15:0] woken_pid;
    logic [15:0] count_after;

    modport source (output valid, status, woken_valid, woken_pid, count_after, input ready);
    modport sink (input valid, status, woken_valid, woken_pid, count_after, output ready);
endinterface

/* src/csem_front.sv */
module csem_front
    import csem_pkg::*;
(
    csem_cmd_if.sink   cmd,
    output job_t       job,
    output logic       job_valid,
    input  logic       job_ready
);

    // handshake passes straight to the job queue
    assign job_valid = cmd.valid;
    assign cmd.ready = job_ready;

    // decode command and normalize the operands
    always_comb
    begin
        job.sem_id   = cmd.sem_id;
        job.pid      = PID_BITS'(cmd.pid);
        job.init_sat = 33'(cmd.init_count) > COUNT_MAX_W;
        job.init     = job.init_sat ? COUNT_MAX : COUNT_BITS'(cmd.init_count);
        unique case (cmd.command)
            CMD_OPEN:   job.op = OP_OPEN;
            CMD_CLOSE:  job.op = OP_CLOSE;
            CMD_POST:   job.op = OP_POST;
            CMD_WAIT:   job.op = OP_WAIT;
            CMD_REMOVE: job.op = OP_REMOVE;
            default:    job.op = OP_NONE;
        endcase
    end

endmodule

/* src/csem_fifo.sv */
module csem_fifo
    import csem_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  job_t wr_data,
    input  logic wr_valid,
    output logic wr_ready,
    output job_t rd_data,
    output logic rd_valid,
    input  logic rd_pop
);

    job_t       data_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;

    assign wr_ready = fill_reg != 2'd2;
    assign rd_valid = fill_reg != 2'd0;
    assign rd_data  = data_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;

    // two entry item queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !rd_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (!push && rd_pop)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* src/csem_back.sv */
module csem_back
    import csem_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       job,
    input  logic       job_valid,
    output logic       job_pop,
    csem_res_if.source res
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_HEAD     = 6'b000010,
        ST_SCAN     = 6'b000100,
        ST_CMP      = 6'b001000,
        ST_SHIFT_RD = 6'b010000,
        ST_SHIFT_WR = 6'b100000
    } state_t;

    state_t                state_reg;
    logic                  valid_reg [NUM_SEMS];
    logic [31:0]           id_reg    [NUM_SEMS];
    logic [COUNT_BITS-1:0] count_reg [NUM_SEMS];
    logic [LEN_W-1:0]      qlen_reg  [NUM_SEMS];
    logic [PID_BITS-1:0]   mem       [MEM_DEPTH];
    logic [PID_BITS-1:0]   rd_data_reg;

    logic [SLOT_W-1:0]     work_reg;
    logic [LEN_W-1:0]      pos_reg;
    logic [PID_BITS-1:0]   pid_reg;

    logic                  res_valid_reg;
    status_t               status_reg;
    logic                  woken_reg;
    logic [PID_BITS-1:0]   wpid_reg;
    logic [COUNT_BITS-1:0] cnt_reg;

    logic                  hit;
    logic [SLOT_W-1:0]     match_idx;
    logic                  any_free;
    logic [SLOT_W-1:0]     free_idx;
    logic [SLOT_W-1:0]     cur_idx;
    logic [COUNT_BITS-1:0] cur_count;
    logic [LEN_W-1:0]      cur_qlen;
    logic [LEN_W-1:0]      pos_inc;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [PID_BITS-1:0]   mem_wdata;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;

    // id lookup and lowest free slot
    always_comb
    begin
        hit       = 1'b0;
        match_idx = '0;
        any_free  = 1'b0;
        free_idx  = '0;
        for (int i = NUM_SEMS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && id_reg[i] == job.sem_id)
            begin
                hit       = 1'b1;
                match_idx = SLOT_W'(i);
            end
            if (!valid_reg[i])
            begin
                any_free = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    // single read port onto the count and queue length columns of the slot table
    assign cur_idx   = (state_reg == ST_IDLE) ? match_idx : work_reg;
    assign cur_count = count_reg[cur_idx];
    assign cur_qlen  = qlen_reg[cur_idx];
    assign pos_inc   = pos_reg + LEN_W'(1);

    // queue memory control
    always_comb
    begin
        job_pop   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid && !res_valid_reg)
                begin
                    job_pop = 1'b1;
                    if (job.op == OP_POST && hit && cur_qlen != '0)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = qaddr(match_idx, '0);
                    end
                    if (job.op == OP_WAIT && hit && cur_count == '0
                        && cur_qlen < LEN_W'(QUEUE_DEPTH))
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = qaddr(match_idx, cur_qlen);
                        mem_wdata = job.pid;
                    end
                end
            end
            ST_SCAN:
            begin
                if (valid_reg[work_reg] && pos_reg < cur_qlen)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = qaddr(work_reg, pos_reg);
                end
            end
            ST_SHIFT_RD:
            begin
                if (pos_inc < cur_qlen)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = qaddr(work_reg, pos_inc);
                end
            end
            ST_SHIFT_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = qaddr(work_reg, pos_reg);
                mem_wdata = rd_data_reg;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    // wait queue storage
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // slot table without reset
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && job_pop)
        begin
            unique case (job.op)
                OP_OPEN:
                begin
                    if (!hit && any_free)
                    begin
                        id_reg[free_idx]    <= job.sem_id;
                        count_reg[free_idx] <= job.init;
                        qlen_reg[free_idx]  <= '0;
                    end
                end
                OP_POST:
                begin
                    if (hit && cur_qlen == '0 && cur_count != COUNT_MAX)
                    begin
                        count_reg[match_idx] <= cur_count + COUNT_BITS'(1);
                    end
                end
                OP_WAIT:
                begin
                    if (hit && cur_count != '0)
                    begin
                        count_reg[match_idx] <= cur_count - COUNT_BITS'(1);
                    end
                    else if (hit && cur_qlen < LEN_W'(QUEUE_DEPTH))
                    begin
                        qlen_reg[match_idx] <= cur_qlen + LEN_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == ST_SHIFT_RD && !(pos_inc < cur_qlen))
        begin
            qlen_reg[work_reg] <= cur_qlen - LEN_W'(1);
        end
    end

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SEMS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_pop)
                    begin
                        woken_reg     <= 1'b0;
                        wpid_reg      <= '0;
                        cnt_reg       <= '0;
                        status_reg    <= STS_NOT_FOUND;
                        res_valid_reg <= 1'b1;
                        case (job.op)
                            OP_OPEN:
                            begin
                                if (hit)
                                begin
                                    status_reg <= STS_OK;
                                    cnt_reg    <= cur_count;
                                end
                                else if (!any_free)
                                begin
                                    status_reg <= STS_TABLE_FULL;
                                end
                                else
                                begin
                                    valid_reg[free_idx] <= 1'b1;
                                    status_reg <= job.init_sat ? STS_OVERFLOW : STS_OK;
                                    cnt_reg    <= job.init;
                                end
                            end
                            OP_CLOSE:
                            begin
                                if (hit && cur_qlen != '0)
                                begin
                                    status_reg <= STS_HAS_WAITERS;
                                    cnt_reg    <= cur_count;
                                end
                                else if (hit)
                                begin
                                    valid_reg[match_idx] <= 1'b0;
                                    status_reg <= STS_OK;
                                end
                            end
                            OP_POST:
                            begin
                                if (hit && cur_qlen != '0)
                                begin
                                    status_reg    <= STS_OK;
                                    cnt_reg       <= cur_count;
                                    woken_reg     <= 1'b1;
                                    work_reg      <= match_idx;
                                    res_valid_reg <= 1'b0;
                                    state_reg     <= ST_HEAD;
                                end
                                else if (hit && cur_count == COUNT_MAX)
                                begin
                                    status_reg <= STS_OVERFLOW;
                                    cnt_reg    <= cur_count;
                                end
                                else if (hit)
                                begin
                                    status_reg <= STS_OK;
                                    cnt_reg    <= cur_count + COUNT_BITS'(1);
                                end
                            end
                            OP_WAIT:
                            begin
                                if (hit && cur_count != '0)
                                begin
                                    status_reg <= STS_OK;
                                    cnt_reg    <= cur_count - COUNT_BITS'(1);
                                end
                                else if (hit && cur_qlen >= LEN_W'(QUEUE_DEPTH))
                                begin
                                    status_reg <= STS_QUEUE_FULL;
                                end
                                else if (hit)
                                begin
                                    status_reg <= STS_BLOCKED;
                                end
                            end
                            OP_REMOVE:
                            begin
                                work_reg      <= '0;
                                pos_reg       <= '0;
                                pid_reg       <= job.pid;
                                res_valid_reg <= 1'b0;
                                state_reg     <= ST_SCAN;
                            end
                            default:
                            begin
                                status_reg <= STS_NOT_FOUND;
                            end
                        endcase
                    end
                end
                ST_HEAD:
                begin
                    wpid_reg  <= rd_data_reg;
                    pos_reg   <= '0;
                    state_reg <= ST_SHIFT_RD;
                end
                ST_SCAN:
                begin
                    if (mem_re)
                    begin
                        state_reg <= ST_CMP;
                    end
                    else if (work_reg == SLOT_W'(NUM_SEMS - 1))
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        work_reg <= work_reg + SLOT_W'(1);
                        pos_reg  <= '0;
                    end
                end
                ST_CMP:
                begin
                    if (rd_data_reg == pid_reg)
                    begin
                        status_reg <= STS_OK;
                        cnt_reg    <= cur_count;
                        state_reg  <= ST_SHIFT_RD;
                    end
                    else
                    begin
                        pos_reg   <= pos_inc;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SHIFT_RD:
                begin
                    if (mem_re)
                    begin
                        state_reg <= ST_SHIFT_WR;
                    end
                    else
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_SHIFT_WR:
                begin
                    pos_reg   <= pos_inc;
                    state_reg <= ST_SHIFT_RD;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result channel
    assign res.valid       = res_valid_reg;
    assign res.status      = status_reg;
    assign res.woken_valid = woken_reg;
    assign res.woken_pid   = 16'(wpid_reg);
    assign res.count_after = 16'(cnt_reg);

endmodule

/* src/counting_semaphore_table.sv */
// channel   role    payload
// cmd       sink    command, sem_id, init_count, pid
// res       source  status, woken_valid, woken_pid, count_after
//
// open, close, wait and post without waiters complete from the idle state of the back end
// post with a waiter reads the queue head, then moves each remaining entry forward one place
// remove scans queue entries one at a time through the single memory read port,
// then moves each entry behind the match forward one place
// reset clears the slot valid bits at once; queue memory needs no clearing
// a two item queue lets commands enter while the back end works or a result is held
module counting_semaphore_table
    import csem_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    csem_cmd_if.sink   cmd,
    csem_res_if.source res
);

    job_t front_job;
    logic front_valid;
    logic front_ready;
    job_t back_job;
    logic back_valid;
    logic back_pop;

    // classify incoming commands
    csem_front u_front (
        .cmd       (cmd),
        .job       (front_job),
        .job_valid (front_valid),
        .job_ready (front_ready)
    );

    // decoupling queue
    csem_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (front_job),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_data  (back_job),
        .rd_valid (back_valid),
        .rd_pop   (back_pop)
    );

    // table and queue engine
    csem_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (back_job),
        .job_valid (back_valid),
        .job_pop   (back_pop),
        .res       (res)
    );

endmodule

/* test/counting_semaphore_table_checker.sv */
`timescale 1ns / 100ps

module counting_semaphore_table_checker
    import csem_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    csem_cmd_if        cmd,
    csem_res_if        res,
    output int         fail_count,
    output int         pending,
    output int         checked,
    output int         woken_seen
);

    typedef struct {
        status_t     status;
        logic        woken_valid;
        logic [15:0] woken_pid;
        logic [15:0] count_after;
    } sem_result_t;

    // shadow copy of the semaphore table
    logic                  tbl_used  [NUM_SEMS];
    logic [31:0]           tbl_id    [NUM_SEMS];
    logic [COUNT_BITS-1:0] tbl_count [NUM_SEMS];
    int                    wait_len  [NUM_SEMS];
    logic [PID_BITS-1:0]   wait_pids [NUM_SEMS][QUEUE_DEPTH];

    sem_result_t results_due[$];

    function automatic int lookup_slot(logic [31:0] id);
        for (int s = 0; s < NUM_SEMS; s++)
            if (tbl_used[s] && tbl_id[s] == id)
                return s;
        return -1;
    endfunction

    function automatic void drop_waiter(int s, int pos);
        for (int k = pos; k + 1 < wait_len[s]; k++)
            wait_pids[s][k] = wait_pids[s][k+1];
        wait_len[s]--;
    endfunction

    // work out the result of one command and update the shadow table
    function automatic sem_result_t apply_command(logic [2:0] op, logic [31:0] id,
                                                  logic [15:0] init, logic [15:0] pid);
        sem_result_t r;
        int s;
        int f;
        bit done;
        r.status      = STS_NOT_FOUND;
        r.woken_valid = 1'b0;
        r.woken_pid   = '0;
        r.count_after = '0;
        s = (op <= CMD_WAIT) ? lookup_slot(id) : -1;
        case (op)
            CMD_OPEN:
            begin
                if (s >= 0)
                begin
                    r.status      = STS_OK;
                    r.count_after = tbl_count[s];
                end
                else
                begin
                    f = 0;
                    while (f < NUM_SEMS && tbl_used[f])
                        f++;
                    if (f == NUM_SEMS)
                        r.status = STS_TABLE_FULL;
                    else
                    begin
                        tbl_used[f]  = 1'b1;
                        tbl_id[f]    = id;
                        wait_len[f]  = 0;
                        tbl_count[f] = init;
                        r.status      = STS_OK;
                        r.count_after = init;
                    end
                end
            end
            CMD_CLOSE:
            begin
                if (s >= 0)
                begin
                    if (wait_len[s] > 0)
                    begin
                        r.status      = STS_HAS_WAITERS;
                        r.count_after = tbl_count[s];
                    end
                    else
                    begin
                        tbl_used[s] = 1'b0;
                        r.status    = STS_OK;
                    end
                end
            end
            CMD_POST:
            begin
                if (s >= 0)
                begin
                    if (wait_len[s] > 0)
                    begin
                        r.woken_valid = 1'b1;
                        r.woken_pid   = wait_pids[s][0];
                        drop_waiter(s, 0);
                        r.status = STS_OK;
                    end
                    else if (tbl_count[s] == COUNT_MAX)
                        r.status = STS_OVERFLOW;
                    else
                    begin
                        tbl_count[s]++;
                        r.status = STS_OK;
                    end
                    r.count_after = tbl_count[s];
                end
            end
            CMD_WAIT:
            begin
                if (s >= 0)
                begin
                    if (tbl_count[s] != 0)
                    begin
                        tbl_count[s]--;
                        r.status = STS_OK;
                    end
                    else if (wait_len[s] >= QUEUE_DEPTH)
                        r.status = STS_QUEUE_FULL;
                    else
                    begin
                        wait_pids[s][wait_len[s]] = pid;
                        wait_len[s]++;
                        r.status = STS_BLOCKED;
                    end
                    r.count_after = tbl_count[s];
                end
            end
            CMD_REMOVE:
            begin
                done = 0;
                for (int t = 0; t < NUM_SEMS && !done; t++)
                begin
                    if (tbl_used[t])
                    begin
                        for (int j = 0; j < wait_len[t] && !done; j++)
                        begin
                            if (wait_pids[t][j] == pid)
                            begin
                                drop_waiter(t, j);
                                r.status      = STS_OK;
                                r.count_after = tbl_count[t];
                                done          = 1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    assign pending = results_due.size();

    // predict on every accepted command, compare every accepted result
    always @(posedge clk or negedge rst_n)
    begin
        sem_result_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SEMS; s++)
            begin
                tbl_used[s] = 1'b0;
                wait_len[s] = 0;
            end
            results_due.delete();
            fail_count = 0;
            checked    = 0;
            woken_seen = 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
                results_due.push_back(apply_command(cmd.command, cmd.sem_id,
                                                    cmd.init_count, cmd.pid));
            if (res.valid && res.ready)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected result status %0d count %0d", $time,
                             res.status, res.count_after);
                    fail_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    checked++;
                    if (want.woken_valid)
                        woken_seen++;
                    if (res.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, res.status);
                        fail_count++;
                    end
                    if (res.woken_valid !== want.woken_valid)
                    begin
                        $display("%0t: woken_valid expected %0b actual %0b", $time,
                                 want.woken_valid, res.woken_valid);
                        fail_count++;
                    end
                    if (res.woken_pid !== want.woken_pid)
                    begin
                        $display("%0t: woken_pid expected %h actual %h", $time,
                                 want.woken_pid, res.woken_pid);
                        fail_count++;
                    end
                    if (res.count_after !== want.count_after)
                    begin
                        $display("%0t: count_after expected %0d actual %0d", $time,
                                 want.count_after, res.count_after);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

/* test/counting_semaphore_table_tb.sv */
`timescale 1ns / 100ps

module counting_semaphore_table_tb;
    import csem_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   checked;
    int   woken_seen;
    int   sent;
    bit   sending_done;

    logic [31:0] id_pool  [20];
    logic [15:0] pid_pool [12];

    csem_cmd_if cmd ();
    csem_res_if res ();

    counting_semaphore_table u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    counting_semaphore_table_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .res        (res),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .woken_seen (woken_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // every few hundred items both sides run without gaps
    function automatic int draw_gap();
        if ((sent / 150) % 3 == 1)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    // send one command item and wait for its acceptance
    task automatic send_cmd(logic [2:0] op, logic [31:0] id, logic [15:0] init,
                            logic [15:0] pid);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            cmd.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd.valid      = 1'b1;
        cmd.command    = op;
        cmd.sem_id     = id;
        cmd.init_count = init;
        cmd.pid        = pid;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_id();
        if ($urandom_range(0, 99) < 88)
            return id_pool[$urandom_range(0, 19)];
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_pid();
        if ($urandom_range(0, 99) < 80)
            return pid_pool[$urandom_range(0, 11)];
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [15:0] pick_init();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 16'($urandom_range(0, 3));
        if (r < 85)
            return 16'($urandom_range(0, 65535));
        return 16'hFFFF - 16'($urandom_range(0, 1));
    endfunction

    // result side stalls at random
    initial
    begin
        int gap;
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = draw_gap();
            res.ready = 1'b0;
            repeat (gap) @(negedge clk);
            res.ready = 1'b1;
            @(posedge clk);
            while (!res.valid)
                @(posedge clk);
        end
    end

    // stimulus
    initial
    begin
        int r;
        logic [31:0] id;
        cmd.valid      = 1'b0;
        cmd.command    = CMD_OPEN;
        cmd.sem_id     = '0;
        cmd.init_count = '0;
        cmd.pid        = '0;
        sent           = 0;
        sending_done   = 0;
        for (int i = 0; i < 20; i++)
            id_pool[i] = $urandom;
        id_pool[0] = 32'h0;
        id_pool[1] = 32'hFFFF_FFFF;
        for (int i = 0; i < 12; i++)
            pid_pool[i] = 16'($urandom_range(0, 65535));
        pid_pool[0] = 16'h0;
        pid_pool[1] = 16'hFFFF;

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: saturated count, post overflow, unknown ids
        send_cmd(CMD_OPEN, 32'hFFFF_FFFF, 16'hFFFF, 16'h0);
        send_cmd(CMD_POST, 32'hFFFF_FFFF, 16'h0, 16'h0);
        send_cmd(CMD_OPEN, 32'hFFFF_FFFF, 16'h0, 16'h0);
        send_cmd(CMD_CLOSE, 32'h1234_5678, 16'h0, 16'h0);
        send_cmd(CMD_POST, 32'h1234_5678, 16'h0, 16'h0);
        send_cmd(CMD_WAIT, 32'h1234_5678, 16'h0, 16'hFFFF);
        // directed: fill one wait queue past its depth
        send_cmd(CMD_OPEN, 32'h0, 16'h0, 16'h0);
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            send_cmd(CMD_WAIT, 32'h0, 16'h0, (i == 0) ? 16'hFFFF : 16'(i));
        send_cmd(CMD_CLOSE, 32'h0, 16'h0, 16'h0);
        send_cmd(CMD_POST, 32'h0, 16'h0, 16'h0);
        send_cmd(CMD_REMOVE, 32'h0, 16'h0, 16'h8);
        send_cmd(CMD_REMOVE, 32'h0, 16'h0, 16'h8);
        for (int c = 5; c < 8; c++)
            send_cmd(3'(c), 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_cmd(CMD_CLOSE, 32'hFFFF_FFFF, 16'h0, 16'h0);

        // random commands over a small id pool so most hit live semaphores
        while (sent < 1700)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                // burst of waits to push a queue to full
                id = pick_id();
                for (int k = 0; k < 18; k++)
                    send_cmd(CMD_WAIT, id, pick_init(), pick_pid());
            end
            else if (r < 23)
                send_cmd(CMD_OPEN, pick_id(), pick_init(), pick_pid());
            else if (r < 33)
                send_cmd(CMD_CLOSE, pick_id(), pick_init(), pick_pid());
            else if (r < 55)
                send_cmd(CMD_POST, pick_id(), pick_init(), pick_pid());
            else if (r < 80)
                send_cmd(CMD_WAIT, pick_id(), pick_init(), pick_pid());
            else if (r < 95)
                send_cmd(CMD_REMOVE, $urandom, pick_init(), pick_pid());
            else
                send_cmd(3'($urandom_range(5, 7)), $urandom,
                         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        end
        cmd.valid    = 1'b0;
        sending_done = 1;
    end

    // drain and verdict
    initial
    begin
        wait (sending_done);
        while (pending != 0)
            @(posedge clk);
        repeat (1200) @(posedge clk);
        $display("sent %0d commands, checked %0d results", sent, checked);
        $display("%0d woken waiters, %0d mismatches", woken_seen, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // timeout
    initial
    begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
src/csem_pkg.sv
src/csem_cmd_if.sv
src/csem_res_if.sv
src/csem_front.sv
src/csem_fifo.sv
src/csem_back.sv
src/counting_semaphore_table.sv
test/counting_semaphore_table_checker.sv
test/counting_semaphore_table_tb.sv
